FILE: hw/rtl/fcl_pkg.sv
`default_nettype none

package fcl_pkg;

    // sizes of the stores
    localparam int MAX_IN  = 64;
    localparam int MAX_OUT = 64;
    localparam int IN_AW   = $clog2(MAX_IN);
    localparam int OUT_AW  = $clog2(MAX_OUT);
    localparam int W_AW    = OUT_AW + IN_AW;
    localparam int W_DEPTH = MAX_OUT << IN_AW;

    // arithmetic
    localparam int DATA_W = 16;
    localparam int PROD_W = 2 * DATA_W;
    localparam int FRAC   = 12;
    localparam int ACC_W  = PROD_W + IN_AW + 2;
    localparam int DIM_W  = 7;
    localparam int ROW_W  = 16;

    // item actions
    localparam logic [1:0] ACT_WEIGHT = 2'd0;
    localparam logic [1:0] ACT_BIAS   = 2'd1;
    localparam logic [1:0] ACT_ELEM   = 2'd2;

    // register indexes
    localparam logic [1:0] REG_IN_DIM    = 2'd0;
    localparam logic [1:0] REG_OUT_DIM   = 2'd1;
    localparam logic [1:0] REG_BIAS_EN   = 2'd2;
    localparam logic [1:0] REG_ROW_COUNT = 2'd3;

    typedef struct packed {
        logic [1:0]         action;
        logic [5:0]         out_channel;
        logic [5:0]         column;
        logic signed [15:0] value;
    } t_in_item;

    typedef struct packed {
        logic signed [15:0] result;
        logic [5:0]         channel;
        logic               last;
        logic               final_row;
        logic               saturated;
    } t_out_item;

    typedef struct packed {
        logic init;
        logic bias_en;
        logic take;
    } t_mac_ctl;

    typedef struct packed {
        logic signed [DATA_W-1:0] result;
        logic                     saturated;
    } t_mac_res;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_LOAD,
        ST_MAC,
        ST_DRAIN
    } t_state;

endpackage

`default_nettype wire

FILE: hw/rtl/dense_layer_matvec_bias.sv
`default_nettype none
// channel  | handshake                        | payload
// ---------+----------------------------------+-------------------------------
// item in  | start, busy (beat when !busy)    | i_item (action, channel, column, value)
// result   | o_valid strobe, one cycle        | o_result (result, channel, flags)
// config   | apb psel/penable/pwrite, pready=1 | paddr, pwdata, prdata
//
// weight, bias and element beats that close no row leave busy low
// the element at column in_dim-1 starts a row and holds busy through it; per
// channel one bias fetch, in_dim issues into the single mac, then the drain
// steps (read data, product, result load)
// reset is synchronous active low; the stores are not cleared
// results cannot be stalled, each is shown for one cycle

module dense_layer_matvec_bias
    import fcl_pkg::*;
(
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    // item channel
    input  wire logic        start,
    output logic             busy,
    input  wire t_in_item    i_item,
    // result channel
    output logic             o_valid,
    output t_out_item        o_result,
    // config port
    input  wire logic        psel,
    input  wire logic        penable,
    input  wire logic        pwrite,
    input  wire logic [3:0]  paddr,
    input  wire logic [31:0] pwdata,
    output logic [31:0]      prdata,
    output logic             pready
);

    // configuration registers
    logic [DIM_W-1:0] r_in_dim;
    logic [DIM_W-1:0] r_out_dim;
    logic             r_bias_en;
    logic [ROW_W-1:0] r_row_count;
    logic [1:0]       reg_idx;
    logic             cfg_wr;

    // stores
    logic signed [DATA_W-1:0] r_wmem [W_DEPTH];
    logic signed [DATA_W-1:0] r_bmem [MAX_OUT];
    logic signed [DATA_W-1:0] r_xmem [MAX_IN];
    logic signed [DATA_W-1:0] r_w_q;
    logic signed [DATA_W-1:0] r_x_q;
    logic signed [DATA_W-1:0] r_b_q;
    logic                     r_rd_valid;

    // sequencer
    t_state             r_state;
    t_state             n_state;
    logic [IN_AW-1:0]   r_k;
    logic [OUT_AW-1:0]  r_chan;
    logic [IN_AW-1:0]   r_ni_m1;
    logic [OUT_AW-1:0]  r_no_m1;
    logic               r_fin;
    logic [ROW_W-1:0]   r_row_cnt;

    logic               accept;
    logic               row_go;
    logic               fin;
    logic [DIM_W-1:0]   ni;
    logic [DIM_W-1:0]   no;
    logic [ROW_W-1:0]   row_next;
    logic               issue;
    logic               out_load;
    logic               drained;
    logic               chan_last;

    t_mac_ctl           mac_ctl;
    t_mac_res           mac_res;
    logic               mac_pending;

    // ---------------- config port ----------------
    assign pready  = 1'b1;
    assign reg_idx = paddr[3:2];
    assign cfg_wr  = psel && penable && pwrite && pready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_dim    <= DIM_W'(64);
            r_out_dim   <= DIM_W'(64);
            r_bias_en   <= 1'b1;
            r_row_count <= ROW_W'(1);
        end else if (cfg_wr) begin
            unique case (reg_idx)
                REG_IN_DIM:    r_in_dim    <= pwdata[DIM_W-1:0];
                REG_OUT_DIM:   r_out_dim   <= pwdata[DIM_W-1:0];
                REG_BIAS_EN:   r_bias_en   <= pwdata[0];
                REG_ROW_COUNT: r_row_count <= pwdata[ROW_W-1:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        unique case (reg_idx)
            REG_IN_DIM:    prdata = 32'(r_in_dim);
            REG_OUT_DIM:   prdata = 32'(r_out_dim);
            REG_BIAS_EN:   prdata = 32'(r_bias_en);
            REG_ROW_COUNT: prdata = 32'(r_row_count);
            default:       prdata = '0;
        endcase
    end

    // ---------------- dims in use ----------------
    // zero counts as one, anything above the store size is clipped
    always_comb begin
        if (r_in_dim == '0) begin
            ni = DIM_W'(1);
        end else if (32'(r_in_dim) > MAX_IN) begin
            ni = DIM_W'(MAX_IN);
        end else begin
            ni = r_in_dim;
        end
        if (r_out_dim == '0) begin
            no = DIM_W'(1);
        end else if (32'(r_out_dim) > MAX_OUT) begin
            no = DIM_W'(MAX_OUT);
        end else begin
            no = r_out_dim;
        end
    end

    assign accept   = start && !busy;
    assign row_go   = accept && (i_item.action == ACT_ELEM) && (32'(i_item.column) < MAX_IN)
                      && (DIM_W'(i_item.column) == ni - DIM_W'(1));
    assign row_next = r_row_cnt + ROW_W'(1);
    assign fin      = (row_next == r_row_count);

    // ---------------- stores ----------------
    always_ff @(posedge i_clk) begin
        if (accept && (i_item.action == ACT_WEIGHT) && (32'(i_item.out_channel) < MAX_OUT)
            && (32'(i_item.column) < MAX_IN)) begin
            r_wmem[{OUT_AW'(i_item.out_channel), IN_AW'(i_item.column)}] <= i_item.value;
        end
        r_w_q <= r_wmem[{r_chan, r_k}];
    end

    always_ff @(posedge i_clk) begin
        if (accept && (i_item.action == ACT_BIAS) && (32'(i_item.out_channel) < MAX_OUT)) begin
            r_bmem[OUT_AW'(i_item.out_channel)] <= i_item.value;
        end
        r_b_q <= r_bmem[r_chan];
    end

    always_ff @(posedge i_clk) begin
        if (accept && (i_item.action == ACT_ELEM) && (32'(i_item.column) < MAX_IN)) begin
            r_xmem[IN_AW'(i_item.column)] <= i_item.value;
        end
        r_x_q <= r_xmem[r_k];
    end

    // read data valid in the cycle after each issue
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_rd_valid <= 1'b0;
        end else begin
            r_rd_valid <= issue;
        end
    end

    // ---------------- sequencer ----------------
    assign drained   = !r_rd_valid && !mac_pending;
    assign chan_last = (r_chan == r_no_m1);

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            ST_IDLE:  if (row_go) n_state = ST_LOAD;
            ST_LOAD:  n_state = ST_MAC;
            ST_MAC:   if (r_k == r_ni_m1) n_state = ST_DRAIN;
            ST_DRAIN: begin
                if (drained) begin
                    n_state = chan_last ? ST_IDLE : ST_LOAD;
                end
            end
            default:  n_state = ST_IDLE;
        endcase
    end

    always_comb begin
        busy     = (r_state != ST_IDLE);
        issue    = (r_state == ST_MAC);
        out_load = (r_state == ST_DRAIN) && drained;
        mac_ctl.take    = r_rd_valid;
        mac_ctl.init    = (r_state == ST_MAC) && (r_k == '0);
        mac_ctl.bias_en = r_bias_en;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= ST_IDLE;
            r_row_cnt <= '0;
            r_k       <= '0;
            r_chan    <= '0;
        end else begin
            r_state <= n_state;
            if (row_go) begin
                r_row_cnt <= fin ? '0 : row_next;
                r_chan    <= '0;
            end else if (out_load && !chan_last) begin
                r_chan <= r_chan + OUT_AW'(1);
            end
            if (r_state == ST_LOAD) begin
                r_k <= '0;
            end else if (issue) begin
                r_k <= r_k + IN_AW'(1);
            end
        end
    end

    // row shape latched when the row closes
    always_ff @(posedge i_clk) begin
        if (row_go) begin
            r_ni_m1 <= IN_AW'(ni - DIM_W'(1));
            r_no_m1 <= OUT_AW'(no - DIM_W'(1));
            r_fin   <= fin;
        end
    end

    // ---------------- shared mac ----------------
    fcl_mac u_mac (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_ctl     (mac_ctl),
        .i_bias    (r_b_q),
        .i_w       (r_w_q),
        .i_x       (r_x_q),
        .o_res     (mac_res),
        .o_pending (mac_pending)
    );

    // ---------------- result register ----------------
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            o_valid <= 1'b0;
        end else begin
            o_valid <= out_load;
        end
    end

    always_ff @(posedge i_clk) begin
        if (out_load) begin
            o_result.result    <= mac_res.result;
            o_result.channel   <= 6'(r_chan);
            o_result.last      <= chan_last;
            o_result.final_row <= r_fin;
            o_result.saturated <= mac_res.saturated;
        end
    end

endmodule

`default_nettype wire

FILE: hw/rtl/fcl_mac.sv
`default_nettype none

module fcl_mac
    import fcl_pkg::*;
(
    input  wire logic                     i_clk,
    input  wire logic                     i_rst_n,
    input  wire t_mac_ctl                 i_ctl,
    input  wire logic signed [DATA_W-1:0] i_bias,
    input  wire logic signed [DATA_W-1:0] i_w,
    input  wire logic signed [DATA_W-1:0] i_x,
    output t_mac_res                      o_res,
    output logic                          o_pending
);

    localparam int SH_W = ACC_W - FRAC;

    logic                     r_prod_valid;
    logic signed [PROD_W-1:0] r_prod;
    logic signed [ACC_W-1:0]  r_acc;
    logic signed [SH_W-1:0]   shifted;
    logic                     ovf;

    // product stage
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_prod_valid <= 1'b0;
        end else begin
            r_prod_valid <= i_ctl.take;
        end
    end

    always_ff @(posedge i_clk) begin
        r_prod <= i_w * i_x;
    end

    // accumulate stage, bias preloaded shifted up to the q.24 product scale
    always_ff @(posedge i_clk) begin
        if (i_ctl.init) begin
            if (i_ctl.bias_en) begin
                r_acc <= ACC_W'(i_bias) <<< FRAC;
            end else begin
                r_acc <= '0;
            end
        end else if (r_prod_valid) begin
            r_acc <= r_acc + ACC_W'(r_prod);
        end
    end

    // floor shift and clip to 16 bits
    always_comb begin
        shifted = r_acc[ACC_W-1:FRAC];
        ovf     = (shifted[SH_W-1:DATA_W-1] != '0) && (shifted[SH_W-1:DATA_W-1] != '1);
        o_res.saturated = ovf;
        if (ovf) begin
            o_res.result = shifted[SH_W-1] ? {1'b1, {(DATA_W-1){1'b0}}}
                                           : {1'b0, {(DATA_W-1){1'b1}}};
        end else begin
            o_res.result = shifted[DATA_W-1:0];
        end
    end

    assign o_pending = r_prod_valid;

endmodule

`default_nettype wire

FILE: hw/rtl/fcl_checker.sv
`default_nettype none

module fcl_checker
    import fcl_pkg::*;
(
    input wire logic      i_clk,
    input wire logic      i_rst_n,
    input wire logic      start,
    input wire logic      busy,
    input wire t_in_item  i_item,
    input wire logic      o_valid,
    input wire t_out_item o_result
);

    // stores writes never hold the block
    a_write_no_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        start && !busy && (i_item.action != ACT_ELEM) |=> !busy)
        else $error("busy after a store write");

    // results are spaced by at least the bias fetch and one mac
    a_result_gap: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |=> !o_valid)
        else $error("back to back result beats");

    // more channels follow while the row is not done
    a_row_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && !o_result.last |-> busy)
        else $error("idle in the middle of a row");

    // busy only rises from an accepted beat
    a_busy_cause: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(busy) |-> $past(start))
        else $error("busy without a start beat");

endmodule

bind dense_layer_matvec_bias fcl_checker u_fcl_checker (
    .i_clk    (i_clk),
    .i_rst_n  (i_rst_n),
    .start    (start),
    .busy     (busy),
    .i_item   (i_item),
    .o_valid  (o_valid),
    .o_result (o_result)
);

`default_nettype wire

FILE: tb/dense_layer_matvec_bias_tb.sv
`default_nettype none

module dense_layer_matvec_bias_tb;
    import fcl_pkg::*;

    // action code that the block drops without a result
    localparam logic [1:0] ACT_NONE = 2'd3;

    // cycles let pass after the last result before a register write
    localparam int IDLE_PAUSE  = 8;
    // drain allowance at the end of the run
    localparam int END_PAUSE   = 50;
    // watchdog, well above the slowest correct run
    localparam int CYCLE_LIMIT = 12000000;
    localparam int SHOWN_FAILS = 10;

    // clock, reset and block ports
    logic        i_clk = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        start = 1'b0;
    logic        busy;
    t_in_item    item_in = '0;
    logic        res_valid;
    t_out_item   res_out;
    logic        psel = 1'b0;
    logic        penable = 1'b0;
    logic        pwrite = 1'b0;
    logic [3:0]  paddr = '0;
    logic [31:0] pwdata = '0;
    logic [31:0] prdata;
    logic        pready;

    // shadow copy of the layer: stores, row counter and registers
    logic signed [15:0] weight_mem [MAX_OUT][MAX_IN];
    logic signed [15:0] bias_mem [MAX_OUT];
    logic signed [15:0] row_mem [MAX_IN];
    bit                 weight_set [MAX_OUT][MAX_IN];
    bit                 bias_set [MAX_OUT];
    bit                 row_set [MAX_IN];
    logic [15:0]        rows_done = '0;
    logic [6:0]         cfg_in_dim = 7'd64;
    logic [6:0]         cfg_out_dim = 7'd64;
    logic               cfg_bias_en = 1'b1;
    logic [15:0]        cfg_row_count = 16'd1;

    // channel results still owed by the block, oldest first
    t_out_item owed_results [$];

    int fail_count = 0;
    int cycle_count = 0;
    int sender_idle_pct = 0;

    dense_layer_matvec_bias i_dut (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .start    (start),
        .busy     (busy),
        .i_item   (item_in),
        .o_valid  (res_valid),
        .o_result (res_out),
        .psel     (psel),
        .penable  (penable),
        .pwrite   (pwrite),
        .paddr    (paddr),
        .pwdata   (pwdata),
        .prdata   (prdata),
        .pready   (pready)
    );

    always #5 i_clk = ~i_clk;

    // zero means one, anything above the store size clips to it
    function automatic int eff_dim(logic [6:0] d, int lim);
        if (d == 7'd0) begin
            return 1;
        end
        if (int'(d) > lim) begin
            return lim;
        end
        return int'(d);
    endfunction

    function automatic t_in_item mk_item(logic [1:0] act, logic [5:0] och, logic [5:0] col,
                                         logic [15:0] val);
        t_in_item it;
        it.action      = act;
        it.out_channel = och;
        it.column      = col;
        it.value       = val;
        return it;
    endfunction

    // q4.12 operand: within plus or minus one or full range in equal parts, some at the rails
    function automatic logic [15:0] rand_q412();
        logic [15:0] v;
        case ($urandom_range(9))
            0: v = 16'h7FFF;
            1: v = 16'h8000;
            2, 3, 4, 5: v = 16'($urandom_range(8191) - 4096);
            default: v = 16'($urandom);
        endcase
        return v;
    endfunction

    // one dot product per channel, exact sum, floor shift, clip to 16 bits
    function automatic void matvec_row();
        int          ni;
        int          no;
        longint      acc;
        longint      r;
        logic        fin;
        t_out_item   res;
        ni  = eff_dim(cfg_in_dim, MAX_IN);
        no  = eff_dim(cfg_out_dim, MAX_OUT);
        fin = (rows_done + 16'd1) == cfg_row_count;
        for (int c = 0; c < no; c++) begin
            acc = cfg_bias_en ? (longint'(bias_mem[c]) <<< FRAC) : 64'sd0;
            for (int k = 0; k < ni; k++) begin
                acc += longint'(weight_mem[c][k]) * longint'(row_mem[k]);
            end
            r = acc >>> FRAC;
            res.saturated = 1'b0;
            if (r > 32767) begin
                r = 32767;
                res.saturated = 1'b1;
            end else if (r < -32768) begin
                r = -32768;
                res.saturated = 1'b1;
            end
            res.result    = r[15:0];
            res.channel   = c[5:0];
            res.last      = (c == no - 1);
            res.final_row = fin;
            owed_results.push_back(res);
        end
        rows_done = fin ? 16'd0 : rows_done + 16'd1;
    endfunction

    // shadow update for one accepted beat
    function automatic void apply_item(t_in_item it);
        case (it.action)
            ACT_WEIGHT: begin
                weight_mem[it.out_channel][it.column] = it.value;
                weight_set[it.out_channel][it.column] = 1'b1;
            end
            ACT_BIAS: begin
                bias_mem[it.out_channel] = it.value;
                bias_set[it.out_channel] = 1'b1;
            end
            ACT_ELEM: begin
                row_mem[it.column] = it.value;
                row_set[it.column] = 1'b1;
                if (int'(it.column) == eff_dim(cfg_in_dim, MAX_IN) - 1) begin
                    matvec_row();
                end
            end
            default: begin
            end
        endcase
    endfunction

    // present one beat, with random sender gaps, and hold it until busy is low
    // start stays high on return so that back to back beats need no toggle
    task automatic issue_item(t_in_item it);
        while ($urandom_range(99) < sender_idle_pct) begin
            start <= 1'b0;
            @(posedge i_clk);
        end
        start   <= 1'b1;
        item_in <= it;
        @(posedge i_clk);
        while (busy) begin
            @(posedge i_clk);
        end
        apply_item(it);
    endtask

    // write every entry that the next row reads and that holds nothing yet
    task automatic fill_unwritten();
        int ni;
        int no;
        ni = eff_dim(cfg_in_dim, MAX_IN);
        no = eff_dim(cfg_out_dim, MAX_OUT);
        for (int c = 0; c < no; c++) begin
            for (int k = 0; k < ni; k++) begin
                if (!weight_set[c][k]) begin
                    issue_item(mk_item(ACT_WEIGHT, 6'(c), 6'(k), rand_q412()));
                end
            end
            if (cfg_bias_en && !bias_set[c]) begin
                issue_item(mk_item(ACT_BIAS, 6'(c), 6'($urandom), rand_q412()));
            end
        end
        for (int k = 0; k < ni - 1; k++) begin
            if (!row_set[k]) begin
                issue_item(mk_item(ACT_ELEM, 6'($urandom), 6'(k), rand_q412()));
            end
        end
    endtask

    // any beat that closes a row first gets its operands written
    task automatic send_checked(t_in_item it);
        if (it.action == ACT_ELEM && int'(it.column) == eff_dim(cfg_in_dim, MAX_IN) - 1) begin
            fill_unwritten();
        end
        issue_item(it);
    endtask

    // one full row of fresh elements, columns in order
    task automatic send_row();
        for (int k = 0; k < eff_dim(cfg_in_dim, MAX_IN); k++) begin
            send_checked(mk_item(ACT_ELEM, 6'($urandom), 6'(k), rand_q412()));
        end
    endtask

    // drop start, wait for every owed result, then let the block settle
    task automatic wait_idle();
        start <= 1'b0;
        while (owed_results.size() != 0) begin
            @(posedge i_clk);
        end
        repeat (IDLE_PAUSE) @(posedge i_clk);
    endtask

    // apb write: setup cycle, access cycle, then psel low again before return
    task automatic write_reg(logic [1:0] idx, logic [31:0] data);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {idx, 2'b00};
        pwdata  <= data;
        @(posedge i_clk);
        penable <= 1'b1;
        @(posedge i_clk);
        while (!pready) begin
            @(posedge i_clk);
        end
        case (idx)
            REG_IN_DIM:    cfg_in_dim    = data[6:0];
            REG_OUT_DIM:   cfg_out_dim   = data[6:0];
            REG_BIAS_EN:   cfg_bias_en   = data[0];
            REG_ROW_COUNT: cfg_row_count = data[15:0];
            default: begin
            end
        endcase
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        @(posedge i_clk);
    endtask

    // rails on the weights, biases and elements: clipping both ways, then floor rounding of a
    // small negative sum with the bias off
    task automatic test_saturation_rounding();
        wait_idle();
        write_reg(REG_IN_DIM, 32'd2);
        write_reg(REG_OUT_DIM, 32'd2);
        write_reg(REG_BIAS_EN, 32'd1);
        write_reg(REG_ROW_COUNT, 32'd3);
        issue_item(mk_item(ACT_WEIGHT, 6'd0, 6'd0, 16'h7FFF));
        issue_item(mk_item(ACT_WEIGHT, 6'd0, 6'd1, 16'h7FFF));
        issue_item(mk_item(ACT_WEIGHT, 6'd1, 6'd0, 16'h8000));
        issue_item(mk_item(ACT_WEIGHT, 6'd1, 6'd1, 16'h7FFF));
        issue_item(mk_item(ACT_BIAS, 6'd0, 6'd0, 16'h7FFF));
        issue_item(mk_item(ACT_BIAS, 6'd1, 6'd63, 16'h8000));
        send_checked(mk_item(ACT_ELEM, 6'd0, 6'd0, 16'h7FFF));
        send_checked(mk_item(ACT_ELEM, 6'd63, 6'd1, 16'h7FFF));
        send_checked(mk_item(ACT_ELEM, 6'd0, 6'd0, 16'h8000));
        send_checked(mk_item(ACT_ELEM, 6'd0, 6'd1, 16'h0000));
        wait_idle();
        write_reg(REG_BIAS_EN, 32'd0);
        send_checked(mk_item(ACT_ELEM, 6'd0, 6'd0, 16'h0001));
        send_checked(mk_item(ACT_ELEM, 6'd0, 6'd1, 16'hFFFF));
    endtask

    // dropped actions and elements past in_dim give nothing back; one full row follows
    task automatic test_ignored_items();
        issue_item(mk_item(ACT_NONE, 6'd63, 6'd63, 16'hFFFF));
        issue_item(mk_item(ACT_NONE, 6'($urandom), 6'($urandom), 16'($urandom)));
        send_checked(mk_item(ACT_ELEM, 6'd0, 6'd63, rand_q412()));
        send_checked(mk_item(ACT_ELEM, 6'd0, 6'($urandom_range(63, 2)), rand_q412()));
        issue_item(mk_item(ACT_NONE, 6'd0, 6'd1, 16'h0000));
        send_row();
    endtask

    // zero, exact maximum and over-range dimensions, one with junk high bits
    task automatic test_dimension_limits();
        wait_idle();
        write_reg(REG_IN_DIM, 32'd0);
        write_reg(REG_OUT_DIM, 32'd0);
        write_reg(REG_BIAS_EN, 32'd1);
        send_row();
        wait_idle();
        write_reg(REG_IN_DIM, 32'd100);
        write_reg(REG_OUT_DIM, 32'd1);
        send_checked(mk_item(ACT_ELEM, 6'($urandom), 6'd63, rand_q412()));
        wait_idle();
        write_reg(REG_IN_DIM, 32'hFFFF_FF7F);
        write_reg(REG_BIAS_EN, 32'd0);
        send_row();
        wait_idle();
        write_reg(REG_IN_DIM, 32'd64);
        send_row();
        wait_idle();
        write_reg(REG_IN_DIM, 32'd1);
        write_reg(REG_OUT_DIM, 32'd64);
        write_reg(REG_BIAS_EN, 32'd1);
        send_row();
        wait_idle();
        write_reg(REG_OUT_DIM, 32'd127);
        send_row();
        send_row();
    endtask

    // pass boundaries: final_row marking, row_count lowered under the
    // counter, the two extremes, then a pass ending two rows ahead
    task automatic test_row_passes();
        wait_idle();
        write_reg(REG_IN_DIM, 32'd1);
        write_reg(REG_OUT_DIM, 32'd1);
        write_reg(REG_ROW_COUNT, 32'd2);
        repeat (3) send_row();
        wait_idle();
        write_reg(REG_ROW_COUNT, 32'hABCD_0005);
        repeat (2) send_row();
        wait_idle();
        write_reg(REG_ROW_COUNT, 32'd1);
        repeat (2) send_row();
        wait_idle();
        write_reg(REG_ROW_COUNT, 32'd0);
        send_row();
        wait_idle();
        write_reg(REG_ROW_COUNT, 32'd65535);
        send_row();
        wait_idle();
        write_reg(REG_ROW_COUNT, {16'd0, rows_done + 16'd2});
        repeat (3) send_row();
    endtask

    // mostly whole rows with random content, the rest loose writes, stray
    // elements and dropped actions; small dims, fresh settings every few beats
    task automatic test_random_traffic(int idle_pct, int beats);
        int sent;
        int next_cfg;
        int pick;
        sender_idle_pct = 0;
        sent     = 0;
        next_cfg = 0;
        while (sent < beats) begin
            if (sent >= next_cfg) begin
                wait_idle();
                write_reg(REG_IN_DIM, ($urandom_range(9) == 0) ? 32'd0 : $urandom_range(8, 1));
                write_reg(REG_OUT_DIM, ($urandom_range(9) == 0) ? 32'd0 : $urandom_range(8, 1));
                write_reg(REG_BIAS_EN, $urandom_range(1));
                write_reg(REG_ROW_COUNT, $urandom_range(4, 1));
                next_cfg += 11;
                sender_idle_pct = idle_pct;
            end
            pick = $urandom_range(99);
            if (pick < 10) begin
                issue_item(mk_item(ACT_WEIGHT, 6'($urandom), 6'($urandom), rand_q412()));
                sent++;
            end else if (pick < 15) begin
                issue_item(mk_item(ACT_BIAS, 6'($urandom), 6'($urandom), rand_q412()));
                sent++;
            end else if (pick < 20) begin
                issue_item(mk_item(ACT_NONE, 6'($urandom), 6'($urandom), 16'($urandom)));
            end else if (pick < 30) begin
                send_checked(mk_item(ACT_ELEM, 6'($urandom), 6'($urandom), rand_q412()));
                sent++;
            end else begin
                send_row();
                sent += eff_dim(cfg_in_dim, MAX_IN);
            end
        end
        sender_idle_pct = 0;
    endtask

    // result checker: each strobed beat against the oldest owed result
    always @(posedge i_clk) begin
        t_out_item want;
        if (i_rst_n && res_valid !== 1'b0) begin
            if (owed_results.size() == 0) begin
                if (fail_count < SHOWN_FAILS) begin
                    $display("unexpected result beat: channel %0d result %0d",
                             res_out.channel, res_out.result);
                end
                fail_count++;
            end else begin
                want = owed_results.pop_front();
                if (res_valid !== 1'b1 || res_out.result !== want.result ||
                    res_out.channel !== want.channel || res_out.last !== want.last ||
                    res_out.final_row !== want.final_row ||
                    res_out.saturated !== want.saturated) begin
                    if (fail_count < SHOWN_FAILS) begin
                        $display("result mismatch: expected ch %0d val %0d last %b fin %b sat %b",
                                 want.channel, want.result, want.last, want.final_row,
                                 want.saturated);
                        $display("                 actual   ch %0d val %0d last %b fin %b sat %b",
                                 res_out.channel, res_out.result, res_out.last,
                                 res_out.final_row, res_out.saturated);
                    end
                    fail_count++;
                end
            end
        end
    end

    // watchdog
    initial begin
        while (cycle_count < CYCLE_LIMIT) begin
            @(posedge i_clk);
            cycle_count++;
        end
        $display("TB_ERROR");
        $finish;
    end

    initial begin
        repeat (9) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        test_saturation_rounding();
        test_ignored_items();
        test_dimension_limits();
        test_row_passes();
        // sender idling phases: none, then 75 and 18 percent, then none again
        test_random_traffic(0, 33);
        test_random_traffic(75, 33);
        test_random_traffic(18, 33);
        test_random_traffic(0, 33);

        wait_idle();
        repeat (END_PAUSE) @(posedge i_clk);
        fail_count += owed_results.size();
        if (fail_count == 0) begin
            $display("TB_OK");
        end else begin
            $display("TB_ERROR");
        end
        $finish;
    end

endmodule

`default_nettype wire

FILE: dense_layer_matvec_bias.f
hw/rtl/fcl_pkg.sv
hw/rtl/fcl_mac.sv
hw/rtl/dense_layer_matvec_bias.sv
hw/rtl/fcl_checker.sv
tb/dense_layer_matvec_bias_tb.sv
